// ===== rtl/sgig_pkg.sv =====
// Shared constants, types and the state encoding of the stitched grid index generator.
`timescale 1ns / 1ps

package sgig_pkg;

    // Quads per grid side; the grid has GRID_RES+1 vertices per side.
    localparam int GRID_RES = 16;

    // Width of a grid coordinate (0 .. GRID_RES).
    localparam int CW = $clog2(GRID_RES + 1);
    // Width of an unbiased vertex index (0 .. (GRID_RES+1)^2 - 1).
    localparam int IW = $clog2((GRID_RES + 1) * (GRID_RES + 1));

    localparam int MASK_W = 4;
    localparam int ROW_W  = 4;
    localparam int VERT_W = 32;

    localparam int IN_DATA_W  = 40;   // mask, row, base
    localparam int OUT_DATA_W = 96;   // three corners

    // Stitch bits of the edge mask.
    localparam int EDGE_L = 0;
    localparam int EDGE_R = 1;
    localparam int EDGE_B = 2;
    localparam int EDGE_T = 3;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CORNER = 5'b00010,
        S_TRI0   = 5'b00100,
        S_TRI1   = 5'b01000,
        S_FLUSH  = 5'b10000
    } t_state;

    // One corner lookup handed to the shared corner unit.
    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic [CW-1:0]     a;
        logic [CW-1:0]     b;
        logic [VERT_W-1:0] base;
    } t_corner_req;

    typedef struct packed {
        logic [VERT_W-1:0] first;
        logic [VERT_W-1:0] second;
        logic [VERT_W-1:0] third;
    } t_tri;

endpackage

// ===== rtl/sgig_corner.sv =====
// Shared corner unit: edge snapping, grid index and base bias for one corner.
`timescale 1ns / 1ps

module sgig_corner (
    input  sgig_pkg::t_corner_req      i_req,
    output logic [sgig_pkg::VERT_W-1:0] o_index
);
    import sgig_pkg::*;

    logic [CW-1:0] a_s;
    logic [CW-1:0] b_s;
    logic [IW-1:0] idx;

    // Snap rules applied in order, each seeing the previous result
    always_comb begin
        a_s = i_req.a;
        b_s = i_req.b;
        if (a_s == '0 && i_req.mask[EDGE_L] && b_s[0]) begin
            b_s = b_s - CW'(1);
        end
        if (a_s == CW'(GRID_RES) && i_req.mask[EDGE_R] && b_s[0]) begin
            b_s = b_s - CW'(1);
        end
        if (b_s == '0 && i_req.mask[EDGE_B] && a_s[0]) begin
            a_s = a_s - CW'(1);
        end
        if (b_s == CW'(GRID_RES) && i_req.mask[EDGE_T] && a_s[0]) begin
            a_s = a_s - CW'(1);
        end
    end

    assign idx     = IW'(a_s) * IW'(GRID_RES + 1) + IW'(b_s);
    assign o_index = i_req.base + VERT_W'(idx);

endmodule

// ===== rtl/stitched_grid_index_generator_core.sv =====
// Top level of the stitched grid index generator: sequencer, corner store and output stage.
`timescale 1ns / 1ps

// Stitched grid index generator.
// Slave channel (s_axis_*) takes one request per quad row: edge mask,
// row index and base vertex. Master channel (m_axis_*) returns one
// request per kept triangle, three biased vertex indices, tlast on the
// last triangle of the row. Rows at or beyond GRID_RES, and rows whose
// triangles all collapse, give no output at all.
// Timing: one shared corner unit forms one corner per cycle, so each
// quad takes four corner lookups followed by two triangle checks.
// s_axis_tready is high only while the sequencer is idle.
// One kept triangle is held back until the next one (or the row end) is
// known, so tlast can be set; a stalled receiver freezes the sequencer
// once both the held triangle and the output register are full. The
// output register keeps its request stable while m_axis_tready is low,
// and a new row may be taken while the final triangle still waits.
// Reset (i_rst_n low, synchronous) empties the output, drops any row in
// flight and returns to idle.
module stitched_grid_index_generator_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: edge_mask[3:0], quad_row[7:4], base_vertex[39:8]
    input  logic [sgig_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: corner_first[31:0], corner_second[63:32], corner_third[95:64]
    output logic [sgig_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tlast     // row_done
);
    import sgig_pkg::*;

    t_state r_state, n_state;

    // Held row
    logic [MASK_W-1:0] r_mask;
    logic [CW-1:0]     r_row;
    logic [VERT_W-1:0] r_base;

    // Column walk and corner select (bit 0: a+1, bit 1: b+1)
    logic [CW-1:0] r_col, n_col;
    logic [1:0]    r_sel, n_sel;

    // Corner shift line: after four shifts [0]=v00 [1]=v10 [2]=v01 [3]=v11
    logic [VERT_W-1:0] r_crn [4];

    // Held-back triangle and output register
    t_tri r_pend;
    logic r_pend_vld, n_pend_vld;
    t_tri r_out;
    logic r_out_vld, n_out_vld;
    logic r_out_last;

    t_corner_req       corner_req;
    logic [VERT_W-1:0] corner_idx;
    t_tri              cand;
    logic              cand_kept;
    logic              out_free;
    logic              accept;
    logic              load_pend;    // candidate goes to the held slot
    logic              move_out;     // held slot goes to the output
    logic              advance;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_vld || m_axis_tready;

    assign corner_req.mask = r_mask;
    assign corner_req.a    = r_row + CW'(r_sel[0]);
    assign corner_req.b    = r_col + CW'(r_sel[1]);
    assign corner_req.base = r_base;

    sgig_corner u_corner (
        .i_req   (corner_req),
        .o_index (corner_idx)
    );

    // Candidate triangle: (v00,v11,v10) first, then (v00,v01,v11).
    // Bias is a bijection mod 2^32, so degeneracy checks on biased values.
    always_comb begin
        cand.first = r_crn[0];
        if (r_state == S_TRI0) begin
            cand.second = r_crn[3];
            cand.third  = r_crn[1];
        end else begin
            cand.second = r_crn[2];
            cand.third  = r_crn[3];
        end
    end

    assign cand_kept = (cand.first != cand.second) && (cand.second != cand.third)
                    && (cand.first != cand.third);

    always_comb begin
        n_state    = r_state;
        n_col      = r_col;
        n_sel      = r_sel;
        n_pend_vld = r_pend_vld;
        load_pend  = 1'b0;
        move_out   = 1'b0;
        advance    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept && (32'(s_axis_tdata[7:4]) < 32'(GRID_RES))) begin
                    n_col   = '0;
                    n_sel   = '0;
                    n_state = S_CORNER;
                end
            end
            S_CORNER: begin
                n_sel = r_sel + 2'd1;
                if (r_sel == 2'd3) begin
                    n_state = S_TRI0;
                end
            end
            S_TRI0, S_TRI1: begin
                if (!cand_kept) begin
                    advance = 1'b1;
                end else if (!r_pend_vld) begin
                    load_pend = 1'b1;
                    advance   = 1'b1;
                end else if (out_free) begin
                    move_out  = 1'b1;
                    load_pend = 1'b1;
                    advance   = 1'b1;
                end
                if (load_pend) begin
                    n_pend_vld = 1'b1;
                end
                if (advance) begin
                    if (r_state == S_TRI0) begin
                        n_state = S_TRI1;
                    end else if (r_col == CW'(GRID_RES - 1)) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_col   = r_col + CW'(1);
                        n_state = S_CORNER;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pend_vld) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    move_out   = 1'b1;
                    n_pend_vld = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (move_out) begin
            n_out_vld = 1'b1;
        end else if (m_axis_tready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_col      <= '0;
            r_sel      <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_mask     <= '0;
            r_row      <= '0;
            r_base     <= '0;
        end else begin
            r_state    <= n_state;
            r_col      <= n_col;
            r_sel      <= n_sel;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
            if (accept) begin
                r_mask <= s_axis_tdata[3:0];
                r_row  <= CW'(s_axis_tdata[7:4]);
                r_base <= s_axis_tdata[39:8];
            end
        end
    end

    // Payload: no reset
    always_ff @(posedge i_clk) begin
        if (r_state == S_CORNER) begin
            r_crn[0] <= r_crn[1];
            r_crn[1] <= r_crn[2];
            r_crn[2] <= r_crn[3];
            r_crn[3] <= corner_idx;
        end
        if (load_pend) begin
            r_pend <= cand;
        end
        if (move_out) begin
            r_out      <= r_pend;
            r_out_last <= (r_state == S_FLUSH);
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out.third, r_out.second, r_out.first};
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== rtl/sgig_checker.sv =====
// Port-level checker for the stitched grid index generator, bound to the top level.
`timescale 1ns / 1ps

module sgig_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [sgig_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [sgig_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tlast
);
    import sgig_pkg::*;

    logic in_acc;
    logic row_ok;

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign row_ok = 32'(s_axis_tdata[7:4]) < 32'(GRID_RES);

    // Stalled output request holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output request changed while stalled");

    // A walked row keeps the input closed next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && row_ok |=> !s_axis_tready)
        else $error("input ready straight after an in-range row");

    // Out-of-range row is swallowed at once
    a_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !row_ok |=> s_axis_tready)
        else $error("out-of-range row not dropped");

    // No collapsed triangle leaves the block
    a_nondegen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[31:0] != m_axis_tdata[63:32])
         && (m_axis_tdata[63:32] != m_axis_tdata[95:64])
         && (m_axis_tdata[31:0] != m_axis_tdata[95:64]))
        else $error("degenerate triangle emitted");

endmodule

bind stitched_grid_index_generator_core sgig_checker u_sgig_checker (.*);

// ===== sim/tb_stitched_grid_index_generator_core.sv =====
// Self-checking testbench for the stitched grid index generator core.
`timescale 1ns / 1ps

module tb_stitched_grid_index_generator_core;

    import sgig_pkg::*;

    // One triangle as the block should return it.
    typedef struct {
        logic [VERT_W-1:0] first;
        logic [VERT_W-1:0] second;
        logic [VERT_W-1:0] third;
        logic              row_end;
    } t_triangle;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    // tdata: edge_mask[3:0], quad_row[7:4], base_vertex[39:8]
    logic [IN_DATA_W-1:0]    s_axis_tdata;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    // tdata: corner_first[31:0], corner_second[63:32], corner_third[95:64]
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic                    m_axis_tlast;

    t_triangle expected_triangles[$];
    int        mismatch_count = 0;
    int        send_idle_pct  = 0;   // chance per cycle that the row source holds off
    int        recv_stall_pct = 0;   // chance per cycle that the sink is not ready

    stitched_grid_index_generator_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Snapped, unbiased index of grid vertex (a,b); rules applied in order,
    // each seeing the coordinates the earlier ones left.
    function automatic int unsigned snapped_vertex(logic [MASK_W-1:0] mask,
                                                   int unsigned a, int unsigned b);
        if (a == 0 && mask[EDGE_L] && (b % 2) == 1)        b = b - 1;
        if (a == GRID_RES && mask[EDGE_R] && (b % 2) == 1) b = b - 1;
        if (b == 0 && mask[EDGE_B] && (a % 2) == 1)        a = a - 1;
        if (b == GRID_RES && mask[EDGE_T] && (a % 2) == 1) a = a - 1;
        return a * (GRID_RES + 1) + b;
    endfunction

    // Works out the triangle list of one accepted row and queues it.
    task automatic queue_row_triangles(logic [MASK_W-1:0] mask, logic [ROW_W-1:0] row,
                                       logic [VERT_W-1:0] base);
        t_triangle   row_tris[$];
        t_triangle   t;
        int unsigned v00, v01, v10, v11;
        int unsigned x[2], y[2], z[2];
        if (row >= GRID_RES) return;   // out-of-range row: nothing comes back
        for (int unsigned jj = 0; jj < GRID_RES; jj++) begin
            v00 = snapped_vertex(mask, 32'(row), jj);
            v10 = snapped_vertex(mask, 32'(row) + 1, jj);
            v01 = snapped_vertex(mask, 32'(row), jj + 1);
            v11 = snapped_vertex(mask, 32'(row) + 1, jj + 1);
            x[0] = v00; y[0] = v11; z[0] = v10;
            x[1] = v00; y[1] = v01; z[1] = v11;
            for (int k = 0; k < 2; k++) begin
                // collapsed triangles are dropped
                if (x[k] != y[k] && y[k] != z[k] && x[k] != z[k]) begin
                    t.first   = x[k] + base;
                    t.second  = y[k] + base;
                    t.third   = z[k] + base;
                    t.row_end = 1'b0;
                    row_tris  = {row_tris, t};
                end
            end
        end
        // tlast only on the final kept triangle; an empty row signals nothing
        if (row_tris.size() > 0) row_tris[row_tris.size() - 1].row_end = 1'b1;
        foreach (row_tris[i]) expected_triangles = {expected_triangles, row_tris[i]};
    endtask

    // Offers one row request; entered and left just after a falling edge.
    task automatic send_row(logic [MASK_W-1:0] mask, logic [ROW_W-1:0] row,
                            logic [VERT_W-1:0] base);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {base, row, mask};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        queue_row_triangles(mask, row, base);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (expected_triangles.size() != 0) @(posedge i_clk);
    endtask

    // Sink side: tready is redrawn every cycle from the current stall rate.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Every accepted output request is matched against the oldest expected triangle.
    always @(posedge i_clk) begin
        t_triangle exp_tri;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_triangles.size() == 0) begin
                $error("unexpected triangle: %h last %b", m_axis_tdata, m_axis_tlast);
                mismatch_count++;
            end else begin
                exp_tri = expected_triangles.pop_front();
                if (m_axis_tdata[31:0] !== exp_tri.first) begin
                    $error("corner_first: expected %h, got %h",
                           exp_tri.first, m_axis_tdata[31:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[63:32] !== exp_tri.second) begin
                    $error("corner_second: expected %h, got %h",
                           exp_tri.second, m_axis_tdata[63:32]);
                    mismatch_count++;
                end
                if (m_axis_tdata[95:64] !== exp_tri.third) begin
                    $error("corner_third: expected %h, got %h",
                           exp_tri.third, m_axis_tdata[95:64]);
                    mismatch_count++;
                end
                if (m_axis_tlast !== exp_tri.row_end) begin
                    $error("row_done: expected %b, got %b", exp_tri.row_end, m_axis_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // Mostly boundary rows, with each single stitch bit and several combined masks, plus base values that wrap.
    task automatic test_edge_rows();
        send_row(4'h0, 4'd0,  32'h0000_0000);
        send_row(4'hF, 4'd0,  32'h0000_0000);
        send_row(4'hF, 4'd15, 32'hFFFF_FFFF);
        send_row(4'h1, 4'd0,  32'h0000_0001);
        send_row(4'h1, 4'd15, 32'h0000_0100);
        send_row(4'h2, 4'd15, 32'hFFFF_FF00);
        send_row(4'h2, 4'd0,  32'h8000_0000);
        send_row(4'h4, 4'd1,  32'hFFFF_FFF0);
        send_row(4'h4, 4'd0,  32'h7FFF_FFFF);
        send_row(4'h8, 4'd14, 32'hAAAA_AAAA);
        send_row(4'h8, 4'd15, 32'h5555_5555);
        send_row(4'h3, 4'd7,  32'h0000_1000);
        send_row(4'hC, 4'd8,  32'hFFFF_FEE0);
        send_row(4'h5, 4'd0,  32'h1234_5678);
        send_row(4'hA, 4'd15, 32'hEDCB_A987);
        send_row(4'h6, 4'd5,  32'h0F0F_0F0F);
        send_row(4'h9, 4'd10, 32'hF0F0_F0F0);
        send_row(4'hF, 4'd7,  32'hFFFF_FFFE);
        send_row(4'h0, 4'd15, 32'hFFFF_FFFF);
        send_row(4'h7, 4'd3,  32'h0000_0000);
    endtask

    // Random rows; edge rows and wrapping bases come up often.
    task automatic test_random_rows(int count, int idle_pct, int stall_pct);
        logic [ROW_W-1:0]  row;
        logic [VERT_W-1:0] base;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) begin
            case ($urandom_range(3))
                0:       row = $urandom_range(1) ? ROW_W'(GRID_RES - 1) : '0;
                default: row = ROW_W'($urandom_range(GRID_RES - 1));
            endcase
            if ($urandom_range(3) == 0) base = 32'hFFFF_FFFF - $urandom_range(300);
            else                        base = $urandom;
            send_row(MASK_W'($urandom_range(15)), row, base);
        end
    endtask

    // Source holds off until the block has fully emptied before each row.
    task automatic test_drained_rows(int count);
        send_idle_pct  = 0;
        recv_stall_pct = 30;
        repeat (count) begin
            send_row(MASK_W'($urandom_range(15)), ROW_W'($urandom_range(GRID_RES - 1)),
                     $urandom);
            s_axis_tvalid <= 1'b0;
            wait_drained();
            @(negedge i_clk);
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_edge_rows();
        test_random_rows(100, 0, 0);
        test_random_rows(100, 53, 0);
        test_random_rows(100, 0, 53);
        test_random_rows(100, 6, 6);
        test_drained_rows(10);

        s_axis_tvalid <= 1'b0;
        wait_drained();
        // wait on to catch any stray output
        repeat (8 * GRID_RES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
